// File: rtl/ima_enc_pkg.sv
// ----------------------------------------------------------------------------
// IMA ADPCM encoder package
// Shared types, register codes and the quantizer step table.
// ----------------------------------------------------------------------------
`default_nettype none

package ima_enc_pkg;

  localparam int unsigned MAX_INDEX = 88;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic CFG_PRESET_PRED = 1'b0;
  localparam logic CFG_PRESET_IDX  = 1'b1;

  // Queue entry: one sample plus the state to load on restart
  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               restart;
    logic signed [15:0] preset_pred;
    logic [6:0]         preset_idx;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [14:0] STEP_TABLE [0:88] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  // Index adaptation from the three magnitude bits
  function automatic logic signed [7:0] index_adjust(input logic [2:0] mag);
    logic signed [7:0] adj;
    if (mag[2]) begin
      adj = $signed({5'd0, mag[1:0], 1'b0}) + 8'sd2;
    end else begin
      adj = -8'sd1;
    end
    return adj;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ima_enc_in_if.sv
// ----------------------------------------------------------------------------
// IMA ADPCM encoder input channel
// Valid/ready channel carrying one PCM sample and its packet flags per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ima_enc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;
  logic               restart;

  modport source (output valid, output sample, output last, output restart, input ready);
  modport sink   (input valid, input sample, input last, input restart, output ready);
endinterface

`default_nettype wire

// File: rtl/ima_enc_out_if.sv
// ----------------------------------------------------------------------------
// IMA ADPCM encoder result channel
// Valid/ready channel carrying one packed code byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ima_enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       half;
  logic       packet_end;

  modport source (output valid, output code_byte, output half, output packet_end,
                  input ready);
  modport sink   (input valid, input code_byte, input half, input packet_end,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/ima_enc_front.sv
// ----------------------------------------------------------------------------
// IMA ADPCM encoder front end
// Holds the preset registers, accepts samples and tags them with the
// clamped restart state before they enter the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ima_enc_front
  import ima_enc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  ima_enc_in_if.sink       in_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire q_status_t   q_status,
  output logic             push,
  output item_t            push_item
);

  logic signed [15:0] preset_pred_r;
  logic [6:0]         preset_idx_r;
  logic [6:0]         preset_idx_clamped;

  // Preset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_pred_r <= '0;
      preset_idx_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESET_PRED: preset_pred_r <= $signed(cfg_data);
        CFG_PRESET_IDX:  preset_idx_r  <= cfg_data[6:0];
        default:         ;
      endcase
    end
  end

  // Out-of-range preset index saturates at the top of the table
  assign preset_idx_clamped = (preset_idx_r > 7'(MAX_INDEX)) ? 7'(MAX_INDEX) : preset_idx_r;

  // Accept while the queue has room
  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && !q_status.full;

  always_comb begin
    push_item.sample      = in_ch.sample;
    push_item.last        = in_ch.last;
    push_item.restart     = in_ch.restart;
    push_item.preset_pred = preset_pred_r;
    push_item.preset_idx  = preset_idx_clamped;
  end

endmodule

`default_nettype wire

// File: rtl/ima_enc_queue.sv
// ----------------------------------------------------------------------------
// IMA ADPCM encoder item queue
// Two-entry FIFO between front end and encoder core.
// ----------------------------------------------------------------------------
`default_nettype none

module ima_enc_queue
  import ima_enc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output q_status_t  q_status
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign q_status.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign head           = entry_r[rptr_r];

  // Pointer and fill count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ima_enc_back.sv
// ----------------------------------------------------------------------------
// IMA ADPCM encoder core
// Quantizes one sample per cycle unless the output register it fills is
// held by out_ch, adapts predictor and step index, pairs codes into bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ima_enc_back
  import ima_enc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire item_t     head,
  input  wire q_status_t q_status,
  output logic           pop,
  ima_enc_out_if.source  out_ch
);

  // Encoder state
  logic signed [15:0] predictor_r, predictor_nxt;
  logic [6:0]         index_r, index_nxt;
  logic [3:0]         pending_r, pending_nxt;
  logic               odd_r, odd_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         code_byte_r;
  logic               half_r;
  logic               packet_end_r;

  logic signed [15:0] base_pred;
  logic [6:0]         base_idx;
  logic [15:0]        step0, step1, step2;
  logic signed [16:0] diff;
  logic [16:0]        diff_abs;
  logic [15:0]        d0, d1, d2;
  logic [16:0]        vpdiff;
  logic               neg;
  logic [2:0]         mag;
  logic [3:0]         code;
  logic signed [17:0] pred_wide;
  logic signed [7:0]  idx_wide;
  logic               emit;
  logic [7:0]         emit_byte;
  logic               emit_half;

  assign pop = !q_status.empty && (!out_valid_r || out_ch.ready);

  // Quantizer: sign, three successive compares against the step
  always_comb begin
    base_pred = head.restart ? head.preset_pred : predictor_r;
    base_idx  = head.restart ? head.preset_idx : index_r;
    step0     = {1'b0, STEP_TABLE[base_idx]};
    step1     = step0 >> 1;
    step2     = step0 >> 2;
    diff      = 17'(head.sample) - 17'(base_pred);
    neg       = diff[16];
    diff_abs  = neg ? 17'(-diff) : 17'(diff);
    d0        = diff_abs[15:0];
    vpdiff    = 17'(step0 >> 3);
    mag       = '0;
    d1        = d0;
    if (d0 >= step0) begin
      mag[2] = 1'b1;
      d1     = d0 - step0;
      vpdiff = vpdiff + 17'(step0);
    end
    d2 = d1;
    if (d1 >= step1) begin
      mag[1] = 1'b1;
      d2     = d1 - step1;
      vpdiff = vpdiff + 17'(step1);
    end
    if (d2 >= step2) begin
      mag[0] = 1'b1;
      vpdiff = vpdiff + 17'(step2);
    end
    code = {neg, mag};
  end

  // Predictor and index update with saturation
  always_comb begin
    if (neg) begin
      pred_wide = 18'(base_pred) - $signed({1'b0, vpdiff});
    end else begin
      pred_wide = 18'(base_pred) + $signed({1'b0, vpdiff});
    end
    priority if (pred_wide > 18'sd32767) begin
      predictor_nxt = 16'sh7fff;
    end else if (pred_wide < -18'sd32768) begin
      predictor_nxt = 16'sh8000;
    end else begin
      predictor_nxt = pred_wide[15:0];
    end

    idx_wide = $signed({1'b0, base_idx}) + index_adjust(mag);
    priority if (idx_wide < 8'sd0) begin
      index_nxt = '0;
    end else if (idx_wide > 8'sd88) begin
      index_nxt = 7'(MAX_INDEX);
    end else begin
      index_nxt = idx_wide[6:0];
    end
  end

  // Nibble pairing
  always_comb begin
    emit        = 1'b0;
    emit_byte   = '0;
    emit_half   = 1'b0;
    pending_nxt = pending_r;
    odd_nxt     = odd_r;
    if (odd_r) begin
      emit        = 1'b1;
      emit_byte   = {code, pending_r};
      pending_nxt = '0;
      odd_nxt     = 1'b0;
    end else if (head.last) begin
      emit        = 1'b1;
      emit_byte   = {4'h0, code};
      emit_half   = 1'b1;
      pending_nxt = '0;
    end else begin
      pending_nxt = code;
      odd_nxt     = 1'b1;
    end
  end

  // Output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      predictor_r <= '0;
      index_r     <= '0;
      pending_r   <= '0;
      odd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        predictor_r <= predictor_nxt;
        index_r     <= index_nxt;
        pending_r   <= pending_nxt;
        odd_r       <= odd_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      code_byte_r  <= emit_byte;
      half_r       <= emit_half;
      packet_end_r <= head.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_byte  = code_byte_r;
  assign out_ch.half       = half_r;
  assign out_ch.packet_end = packet_end_r;

  // Checks
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    index_r <= 7'(MAX_INDEX))
    else $error("step index left table range");

  a_half_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && half_r |-> packet_end_r && (code_byte_r[7:4] == 4'h0))
    else $error("half byte without packet end or with high nibble set");

  a_first_nibble_held: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !odd_r && !head.last |=> odd_r && !$past(out_valid_nxt && !out_valid_r))
    else $error("unpaired code did not set odd phase or produced a result");

  a_pair_completes: assert property (@(posedge clk) disable iff (!rst_n)
    pop && odd_r |=> !odd_r && out_valid_r && !half_r)
    else $error("second code did not produce a full byte");

endmodule

`default_nettype wire

// File: rtl/ima_adpcm_encoder_unit.sv
// ----------------------------------------------------------------------------
// IMA ADPCM encoder unit
// 4-bit IMA/DVI ADPCM encoder with two codes packed per byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one signed 16-bit PCM sample per beat with last and restart
//   flags. restart loads predictor and step index from the preset registers
//   before the sample is encoded; last closes a packet and flushes an odd
//   code as a half byte (low nibble only, half set).
//   out_ch carries one code byte per two samples, first code in the low
//   nibble. packet_end marks the byte caused by a last sample.
//   cfg_we/cfg_index/cfg_data write the preset registers (index 0: preset
//   predictor, index 1: preset index, saturated to 88 when used).
// Timing:
//   One sample per cycle sustained while out_ch is ready. A sample is held
//   in the queue, then its result in the output register; the encoder core
//   does the whole quantize/adapt step combinationally between the two.
//   A two-entry queue sits between input and core; when out_ch stalls the
//   core holds its output register and the queue absorbs up to two samples
//   before in_ch.ready drops.
// Reset: synchronous, active low; clears presets, predictor, index, pending
//   nibble, pairing phase, the queue and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ima_adpcm_encoder_unit
  import ima_enc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  ima_enc_in_if.sink       in_ch,
  ima_enc_out_if.source    out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic      push;
  logic      pop;
  item_t     push_item;
  item_t     head;
  q_status_t q_status;

  // Accept and tag samples
  ima_enc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue
  ima_enc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  // Encoder core and output register
  ima_enc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
